FILE: rtl/core/ssbc_pkg.sv
// Shared types, step tables and constants for the six-step commutator.
`default_nettype none
package ssbc_pkg;

  localparam int PULSE_BITS = 16;
  localparam int NUM_PHASES = 3;
  localparam int NUM_STEPS  = 6;

  typedef logic [PULSE_BITS-1:0] pulse_t;
  typedef logic [2:0]            step_t;
  typedef logic [1:0]            phase_t;

  localparam step_t STEP_FIRST = 3'd1;
  localparam step_t STEP_LAST  = 3'd6;

  localparam logic CFG_MODULATION_MODE = 1'b0;
  localparam logic CFG_MAX_PULSE       = 1'b1;

  localparam pulse_t MAX_PULSE_RESET = '1;

  localparam phase_t OFF_PHASE  [NUM_STEPS] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};
  localparam phase_t HIGH_PHASE [NUM_STEPS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam phase_t LOW_PHASE  [NUM_STEPS] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
  localparam phase_t HALL_PHASE [NUM_STEPS] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

  typedef struct packed {
    step_t                         step;
    logic [2*NUM_PHASES-1:0]       sw_en;
    logic [NUM_PHASES-1:0][PULSE_BITS-1:0] cmp;
    phase_t                        hall_sel;
    logic                          hall_pol;
  } bridge_state_t;

  typedef struct packed {
    logic   mode;
    pulse_t max_pulse;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/ssbc_step_logic.sv
// Next bridge, compare and Hall state for one commutation request.
`default_nettype none
module ssbc_step_logic (
  input  ssbc_pkg::bridge_state_t cur_i,
  input  ssbc_pkg::cfg_t          cfg_i,
  input  logic                    ccw_i,
  input  ssbc_pkg::pulse_t        duty_i,
  output ssbc_pkg::bridge_state_t nxt_o
);

  logic             in_range;
  ssbc_pkg::step_t  idx;
  ssbc_pkg::phase_t off_p;
  ssbc_pkg::phase_t hi_p;
  ssbc_pkg::phase_t lo_p;
  ssbc_pkg::pulse_t hi_val;
  ssbc_pkg::pulse_t lo_val;

  assign in_range = cur_i.step inside {[ssbc_pkg::STEP_FIRST:ssbc_pkg::STEP_LAST]};
  assign idx      = in_range ? (cur_i.step - 3'd1) : 3'd0;
  assign off_p    = ssbc_pkg::OFF_PHASE[idx];
  assign hi_p     = ssbc_pkg::HIGH_PHASE[idx];
  assign lo_p     = ssbc_pkg::LOW_PHASE[idx];
  assign hi_val   = cfg_i.mode ? cfg_i.max_pulse : duty_i;
  assign lo_val   = cfg_i.mode ? duty_i : cfg_i.max_pulse;

  always_comb begin
    nxt_o = cur_i;
    if (in_range) begin
      for (int p = 0; p < ssbc_pkg::NUM_PHASES; p++) begin
        if (off_p == 2'(p)) begin
          nxt_o.sw_en[2*p]   = 1'b0;
          nxt_o.sw_en[2*p+1] = 1'b0;
        end
        if (hi_p == 2'(p)) begin
          nxt_o.sw_en[2*p] = 1'b1;
          nxt_o.cmp[p]     = hi_val;
        end
        if (lo_p == 2'(p)) begin
          nxt_o.sw_en[2*p+1] = 1'b1;
          nxt_o.cmp[p]       = lo_val;
        end
      end
      nxt_o.hall_sel = ssbc_pkg::HALL_PHASE[idx];
      nxt_o.hall_pol = ccw_i ^ cur_i.step[0];
      if (ccw_i) begin
        nxt_o.step = (cur_i.step == ssbc_pkg::STEP_FIRST) ? ssbc_pkg::STEP_LAST
                                                          : cur_i.step - 3'd1;
      end else begin
        nxt_o.step = (cur_i.step == ssbc_pkg::STEP_LAST) ? ssbc_pkg::STEP_FIRST
                                                         : cur_i.step + 3'd1;
      end
    end else begin
      nxt_o.sw_en = '0;
      nxt_o.step  = ccw_i ? ssbc_pkg::STEP_LAST : ssbc_pkg::STEP_FIRST;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/six_step_bldc_commutator_unit.sv
// Top level of the six-step commutator: request register, step logic, result register.
//
// Each input request is one commutation event (direction, duty). The block
// answers every request with one result: the six switch enables, the three
// phase compares, the Hall channel and edge to watch, and the next step.
// Requests are taken on in_valid_i && in_ready_o, results leave on
// out_valid_o && out_ready_i.
// A result passes from the request register through the step table into the
// result register, which takes it once the receiver is not stalling it;
// out_valid_o rises as the result register takes it.
// Throughput is one request per cycle unless the receiver stalls; the result
// register's state feeds the step table, so consecutive requests chain with no gap.
// When the receiver stalls, the result holds and one further request waits in
// the request register; in_ready_o drops only when both are full.
// Reset clears both valid flags, sets step 0 (out of range), all switches off,
// compares and Hall selection zero, modulation mode 0 and max pulse all ones.
// The first request after reset turns the bridge off and starts at step 1
// (clockwise) or step 6 (counter-clockwise).
// Configuration writes are registered and must be made while idle.
`default_nettype none
module six_step_bldc_commutator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        direction_ccw_i,
  input  logic [15:0] duty_pulse_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        a_high_on_o,
  output logic        a_low_on_o,
  output logic        b_high_on_o,
  output logic        b_low_on_o,
  output logic        c_high_on_o,
  output logic        c_low_on_o,
  output logic [15:0] compare_a_o,
  output logic [15:0] compare_b_o,
  output logic [15:0] compare_c_o,
  output logic [1:0]  watched_hall_o,
  output logic        hall_edge_falling_o,
  output logic [2:0]  next_step_o
);

  ssbc_pkg::cfg_t          cfg_q;
  logic                    req_valid_q;
  logic                    req_ccw_q;
  ssbc_pkg::pulse_t        req_duty_q;
  logic                    out_valid_q;
  ssbc_pkg::bridge_state_t state_q;
  ssbc_pkg::bridge_state_t state_d;
  logic                    advance;

  assign advance    = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= 1'b0;
      cfg_q.max_pulse <= ssbc_pkg::MAX_PULSE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ssbc_pkg::CFG_MODULATION_MODE: cfg_q.mode      <= cfg_data_i[0];
        ssbc_pkg::CFG_MAX_PULSE:       cfg_q.max_pulse <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_ccw_q  <= direction_ccw_i;
      req_duty_q <= duty_pulse_i;
    end
  end

  ssbc_step_logic u_step (
    .cur_i  (state_q),
    .cfg_i  (cfg_q),
    .ccw_i  (req_ccw_q),
    .duty_i (req_duty_q),
    .nxt_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign a_high_on_o         = state_q.sw_en[0];
  assign a_low_on_o          = state_q.sw_en[1];
  assign b_high_on_o         = state_q.sw_en[2];
  assign b_low_on_o          = state_q.sw_en[3];
  assign c_high_on_o         = state_q.sw_en[4];
  assign c_low_on_o          = state_q.sw_en[5];
  assign compare_a_o         = state_q.cmp[0];
  assign compare_b_o         = state_q.cmp[1];
  assign compare_c_o         = state_q.cmp[2];
  assign watched_hall_o      = state_q.hall_sel;
  assign hall_edge_falling_o = state_q.hall_pol;
  assign next_step_o         = state_q.step;

endmodule
`default_nettype wire

FILE: verif/six_step_bldc_commutator_unit_tb.sv
// Self-checking testbench for the six-step commutator: directed, random and back-pressure traffic.
`default_nettype none
module six_step_bldc_commutator_unit_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 4;

  localparam ssbc_pkg::phase_t DARK_TAB [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};
  localparam ssbc_pkg::phase_t SRC_TAB  [6] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam ssbc_pkg::phase_t SINK_TAB [6] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
  localparam ssbc_pkg::phase_t SENSE_TAB[6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

  typedef struct packed {
    logic [5:0]       sw;
    ssbc_pkg::pulse_t cmp_a;
    ssbc_pkg::pulse_t cmp_b;
    ssbc_pkg::pulse_t cmp_c;
    ssbc_pkg::phase_t hall;
    logic             falling;
    ssbc_pkg::step_t  nstep;
  } bridge_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        direction_ccw_i = 1'b0;
  logic [15:0] duty_pulse_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        a_high_on_o, a_low_on_o, b_high_on_o, b_low_on_o, c_high_on_o, c_low_on_o;
  logic [15:0] compare_a_o, compare_b_o, compare_c_o;
  logic [1:0]  watched_hall_o;
  logic        hall_edge_falling_o;
  logic [2:0]  next_step_o;

  six_step_bldc_commutator_unit dut (.*);

  // commutation state mirrored from the bridge
  ssbc_pkg::step_t  bridge_step = '0;
  logic [5:0]       bridge_sw = '0;
  ssbc_pkg::pulse_t bridge_cmp [3] = '{default: '0};
  ssbc_pkg::phase_t watch_hall = '0;
  logic             watch_falling = 1'b0;
  logic             mode_low_side = 1'b0;
  ssbc_pkg::pulse_t full_pulse = '1;

  bridge_out_t commutation_q [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          in_idle_en = 1'b0;
  bit          out_idle_en = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          rx_hold = 0;
  int          rx_wait = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bridge_out_t commutate(input logic ccw, input ssbc_pkg::pulse_t duty);
    bridge_out_t      r;
    int               idx;
    ssbc_pkg::phase_t hp;
    ssbc_pkg::phase_t lp;
    if (bridge_step inside {[ssbc_pkg::STEP_FIRST:ssbc_pkg::STEP_LAST]}) begin
      idx = bridge_step - 1;
      hp = SRC_TAB[idx];
      lp = SINK_TAB[idx];
      bridge_sw[2*DARK_TAB[idx] +: 2] = 2'b00;
      bridge_sw[2*hp] = 1'b1;
      bridge_sw[2*lp+1] = 1'b1;
      bridge_cmp[hp] = mode_low_side ? full_pulse : duty;
      bridge_cmp[lp] = mode_low_side ? duty : full_pulse;
      watch_hall = SENSE_TAB[idx];
      watch_falling = bridge_step[0] ^ ccw;
      if (ccw) begin
        bridge_step = (bridge_step == ssbc_pkg::STEP_FIRST) ? ssbc_pkg::STEP_LAST
                                                            : 3'(bridge_step - 1);
      end else begin
        bridge_step = (bridge_step == ssbc_pkg::STEP_LAST) ? ssbc_pkg::STEP_FIRST
                                                           : 3'(bridge_step + 1);
      end
    end else begin
      bridge_sw = '0;
      bridge_step = ccw ? ssbc_pkg::STEP_LAST : ssbc_pkg::STEP_FIRST;
    end
    r.sw = bridge_sw;
    r.cmp_a = bridge_cmp[0];
    r.cmp_b = bridge_cmp[1];
    r.cmp_c = bridge_cmp[2];
    r.hall = watch_hall;
    r.falling = watch_falling;
    r.nstep = bridge_step;
    return r;
  endfunction

  task automatic send_event(input logic ccw, input ssbc_pkg::pulse_t duty);
    int gap;
    gap = in_idle_en ? $urandom_range(5, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    direction_ccw_i <= ccw;
    duty_pulse_i <= duty;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    commutation_q.push_back(commutate(ccw, duty));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (commutation_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ssbc_pkg::CFG_MODULATION_MODE) begin
      mode_low_side = val[0];
    end else begin
      full_pulse = val;
    end
    @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    bridge_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (commutation_q.size() == 0) begin
        $display("%0t unexpected result expected none actual step %h", $time, next_step_o);
        mismatch_count++;
      end else begin
        want = commutation_q.pop_front();
        report_field("a_high_on", 16'(want.sw[0]), 16'(a_high_on_o));
        report_field("a_low_on", 16'(want.sw[1]), 16'(a_low_on_o));
        report_field("b_high_on", 16'(want.sw[2]), 16'(b_high_on_o));
        report_field("b_low_on", 16'(want.sw[3]), 16'(b_low_on_o));
        report_field("c_high_on", 16'(want.sw[4]), 16'(c_high_on_o));
        report_field("c_low_on", 16'(want.sw[5]), 16'(c_low_on_o));
        report_field("compare_a", want.cmp_a, compare_a_o);
        report_field("compare_b", want.cmp_b, compare_b_o);
        report_field("compare_c", want.cmp_c, compare_c_o);
        report_field("watched_hall", 16'(want.hall), 16'(watched_hall_o));
        report_field("hall_edge_falling", 16'(want.falling), 16'(hall_edge_falling_o));
        report_field("next_step", 16'(want.nstep), 16'(next_step_o));
      end
    end
  end

  always @(posedge clk_i) begin : result_pacing
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      rx_hold = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      rx_wait = out_idle_en ? $urandom_range(5, 0) : 0;
      out_ready_i <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready_i <= (rx_wait == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_power_up();
    ssbc_pkg::pulse_t duties [7] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
                                     16'hAAAA, 16'h5555};
    // first request finds the step out of range: bridge off, restart at six
    send_event(1'b1, 16'h1234);
    foreach (duties[i]) send_event(1'b0, duties[i]);
    foreach (duties[i]) send_event(1'b1, ~duties[i]);
    drain_results();
  endtask

  task automatic test_low_side_mode();
    write_reg(ssbc_pkg::CFG_MODULATION_MODE, 16'h0001);
    write_reg(ssbc_pkg::CFG_MAX_PULSE, 16'h0000);
    send_event(1'b0, 16'h1357);
    send_event(1'b0, 16'hFFFF);
    send_event(1'b1, 16'h0000);
    send_event(1'b1, 16'hC0DE);
    drain_results();
    write_reg(ssbc_pkg::CFG_MAX_PULSE, 16'hFFFF);
    send_event(1'b1, 16'h0000);
    send_event(1'b0, 16'hFFFF);
    send_event(1'b0, 16'h00FF);
    send_event(1'b0, 16'hFF00);
    drain_results();
  endtask

  task automatic test_backpressure();
    in_idle_en = 1'b0;
    hold_req <= hold_req + 1;
    repeat (30) begin
      send_event(1'($urandom_range(1, 0)), ssbc_pkg::pulse_t'($urandom_range(16'hFFFF, 0)));
    end
    drain_results();
  endtask

  task automatic test_random_traffic(input int phases);
    logic             ccw;
    ssbc_pkg::pulse_t duty;
    ssbc_pkg::pulse_t cap;
    for (int ph = 0; ph < phases; ph++) begin
      case ($urandom_range(2, 0))
        0: cap = '0;
        1: cap = '1;
        default: cap = ssbc_pkg::pulse_t'($urandom_range(16'hFFFF, 0));
      endcase
      write_reg(ssbc_pkg::CFG_MODULATION_MODE, 16'($urandom_range(1, 0)));
      write_reg(ssbc_pkg::CFG_MAX_PULSE, cap);
      in_idle_en = (ph % 3 != 0);
      out_idle_en <= (ph % 2 != 0);
      ccw = 1'($urandom_range(1, 0));
      repeat (85) begin
        if ($urandom_range(7, 0) == 0) ccw = ~ccw;
        case ($urandom_range(7, 0))
          0: duty = '0;
          1: duty = '1;
          default: duty = ssbc_pkg::pulse_t'($urandom_range(16'hFFFF, 0));
        endcase
        send_event(ccw, duty);
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_power_up();
    test_low_side_mode();
    test_backpressure();
    test_random_traffic(6);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && commutation_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/ssbc_pkg.sv
rtl/core/ssbc_step_logic.sv
rtl/core/six_step_bldc_commutator_unit.sv
verif/six_step_bldc_commutator_unit_tb.sv
